@@ src/pmt_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet tracker.
// Used by the front, queue, back and top modules; depends on nothing.
`default_nettype none
package pmt_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = 13;
    localparam int DELTA_BITS = 10;
    localparam int SUM_BITS   = ((COORD_BITS > DELTA_BITS - 1) ? COORD_BITS : DELTA_BITS - 1) + 2;
    localparam int LIM_BITS   = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int OUT_BITS   = ((2 * COORD_BITS + 3 + 7) / 8) * 8;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    localparam logic [7:0] HDR_VALID = 8'b0000_1000;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(768);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } t_phase;

    // One framed packet as handed from the front to the back.
    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } t_packet;

endpackage
`default_nettype wire

@@ src/ps2_mouse_packet_tracker.sv @@
// PS/2 mouse packet tracker top level.
// Instantiates pmt_front, pmt_queue and pmt_back; depends on pmt_pkg.
//
// Usage:
//   s_axis carries one received mouse byte per item in tdata[7:0].
//   m_axis carries one item per completed three-byte packet.
//   The cfg channel writes screen_width (index 0) and screen_height
//   (index 1); other indexes are ignored. cfg_ready is always high.
// Timing:
//   A byte is taken every cycle while the packet queue has room. The
//   result for a packet first enters the queue; once the output register
//   is free, the position update and clamp load it into the output
//   register. Throughput is one byte per cycle while the queue has room.
// Reset:
//   Clears the framing state, the queue and the output valid; the cursor
//   returns to 0,0, screen size to 1024x768, and the next byte is dropped.
// Stall:
//   A held result keeps its register; the back end stops popping, the
//   two-entry queue fills, and s_axis_tready drops only when it is full.
`default_nettype none
module ps2_mouse_packet_tracker
    import pmt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [7:0]              s_axis_tdata,   // [7:0] data_byte
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [24] button_left,
    // [25] button_right, [26] button_middle, rest zero
    output logic [OUT_BITS-1:0]          m_axis_tdata,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]    i_cfg_data
);

    logic    push, q_full, pop, q_valid;
    t_packet front_pkt, q_pkt;

    assign o_cfg_ready = 1'b1;

    pmt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .o_byte_ready (s_axis_tready),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_packet     (front_pkt)
    );

    pmt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_packet (front_pkt),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_packet (q_pkt)
    );

    pmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_packet    (q_pkt),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

endmodule
`default_nettype wire

@@ src/pmt_front.sv @@
// Byte framing front end: drops the first byte, frames header/X/Y packets.
// Depends on pmt_pkg; pushes complete packets into pmt_queue.
`default_nettype none
module pmt_front
    import pmt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_byte_valid,
    input  wire logic [7:0] i_byte,
    output logic         o_byte_ready,
    input  wire logic    i_q_full,
    output logic         o_push,
    output t_packet      o_packet
);

    logic       r_skip, n_skip;
    t_phase     r_phase, n_phase;
    logic [7:0] r_hdr, n_hdr;
    logic [7:0] r_xb, n_xb;
    logic       take;

    assign o_byte_ready = !i_q_full;
    assign take         = i_byte_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip  <= 1'b1;
            r_phase <= PH_HEADER;
        end else begin
            r_skip  <= n_skip;
            r_phase <= n_phase;
        end
        r_hdr <= n_hdr;
        r_xb  <= n_xb;
    end

    always_comb begin
        n_skip   = r_skip;
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_xb     = r_xb;
        o_push   = 1'b0;
        o_packet = '{hdr: r_hdr, x_byte: r_xb, y_byte: i_byte};
        if (take) begin
            if (r_skip) begin
                n_skip = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_XDELTA: begin
                        n_xb    = i_byte;
                        n_phase = PH_YDELTA;
                    end
                    PH_YDELTA: begin
                        n_phase = PH_HEADER;
                        o_push  = 1'b1;
                    end
                    default: begin
                        // hold phase 0 until a byte with the sync bit set
                        n_phase = PH_HEADER;
                        if ((i_byte & HDR_VALID) != 8'd0) begin
                            n_hdr   = i_byte;
                            n_phase = PH_XDELTA;
                        end
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ src/pmt_queue.sv @@
// Two-entry packet queue between the framing front and the cursor back end.
// Depends on pmt_pkg for the packet type.
`default_nettype none
module pmt_queue
    import pmt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_packet i_packet,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_packet      o_packet
);

    t_packet    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_packet = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop && o_valid) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_packet;
        end
    end

endmodule
`default_nettype wire

@@ src/pmt_back.sv @@
// Cursor back end: applies packet deltas, clamps to the screen, holds result.
// Depends on pmt_pkg; owns the screen size registers.
`default_nettype none
module pmt_back
    import pmt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]    i_cfg_data,
    input  wire logic                    i_q_valid,
    input  wire t_packet                 i_packet,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [OUT_BITS-1:0]          o_data
);

    logic [SIZE_BITS-1:0]  r_width, r_height;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic                  r_valid;
    logic [2:0]            r_buttons;
    logic [COORD_BITS-1:0] lim_x, lim_y;
    logic [DELTA_BITS-1:0] dx, dy;

    function automatic logic [DELTA_BITS-1:0] axis_delta(input logic [7:0] b,
                                                         input logic neg,
                                                         input logic ovf);
        logic [DELTA_BITS-1:0] d;
        if (!neg) begin
            d = {2'b00, b};
            if (ovf) d = d + DELTA_BITS'(255);
        end else begin
            // b - 256, except a zero byte means no movement
            d = (b == 8'd0) ? '0 : {2'b11, b};
            if (ovf) d = d - DELTA_BITS'(255);
        end
        return d;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_limit(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] l;
        l = (size == '0) ? '0 : size - SIZE_BITS'(1);
        if (LIM_BITS'(l) > LIM_BITS'(COORD_MAX)) begin
            return COORD_MAX;
        end
        return COORD_BITS'(l);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [SUM_BITS-1:0] v,
                                                          input logic [COORD_BITS-1:0] lim);
        if (v[SUM_BITS-1]) begin
            return '0;
        end
        if (v > SUM_BITS'(lim)) begin
            return lim;
        end
        return v[COORD_BITS-1:0];
    endfunction

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        logic [SUM_BITS-1:0] sx, sy;
        lim_x   = clamp_limit(r_width);
        lim_y   = clamp_limit(r_height);
        dx      = axis_delta(i_packet.x_byte, i_packet.hdr[4], i_packet.hdr[6]);
        dy      = axis_delta(i_packet.y_byte, i_packet.hdr[5], i_packet.hdr[7]);
        sx      = SUM_BITS'(r_pos_x) + {{(SUM_BITS-DELTA_BITS){dx[DELTA_BITS-1]}}, dx};
        sy      = SUM_BITS'(r_pos_y) - {{(SUM_BITS-DELTA_BITS){dy[DELTA_BITS-1]}}, dy};
        n_pos_x = clamp_coord(sx, lim_x);
        n_pos_y = clamp_coord(sy, lim_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SCREEN_WIDTH) begin
                    r_width <= i_cfg_data;
                end else if (i_cfg_index == REG_SCREEN_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
            if (o_pop) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_buttons <= i_packet.hdr[2:0];
        end
    end

    assign o_valid = r_valid;
    assign o_data  = OUT_BITS'({r_buttons[2], r_buttons[1], r_buttons[0], r_pos_y, r_pos_x});

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for ps2_mouse_packet_tracker: mouse bytes in, cursor results out.
// Tracks framing, deltas and clamping in its own cursor tracker; depends on pmt_pkg.
`timescale 1ns / 100ps
module tb;
    import pmt_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int WATCHDOG      = 2000;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
        logic                  mid;
    } t_cursor;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [SIZE_BITS-1:0]  val;
        bit                    typed;
        t_cursor               want;
    } t_step;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = 8'h00;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]     m_axis_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [SIZE_BITS-1:0]    i_cfg_data = '0;

    ps2_mouse_packet_tracker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Cursor tracker state, at reset values.
    logic [SIZE_BITS-1:0] scr_w = RESET_WIDTH;
    logic [SIZE_BITS-1:0] scr_h = RESET_HEIGHT;
    bit                   skip_first = 1'b1;
    t_phase               frame_ph = PH_HEADER;
    logic [7:0]           hdr_byte = 8'h00;
    logic [7:0]           x_byte = 8'h00;
    int                   cur_x = 0;
    int                   cur_y = 0;

    t_cursor cursor_q[$];
    int      err_count = 0;
    int      idle_cycles = 0;

    // Sender and receiver pacing.
    int      burst_max = 4;
    int      gap_max = 3;
    int      burst_left = 0;
    int      rx_period = 5;
    int      rx_low = 2;
    int      rx_cnt = 0;
    int      hold_asked = 0;
    int      hold_taken = 0;
    int      hold_left = 0;

    // Typed expectation for the byte now on offer.
    bit      row_typed = 1'b0;
    t_cursor row_want = '0;

    function automatic int axis_move(input logic [7:0] b, input bit neg, input bit ovf);
        int d;
        if (!neg) begin
            d = int'(b);
            if (ovf) d += 255;
        end else begin
            // a zero byte with the sign set means no motion
            d = -((256 - int'(b)) % 256);
            if (ovf) d -= 255;
        end
        return d;
    endfunction

    function automatic int clamp_to(input int v, input logic [SIZE_BITS-1:0] size);
        int lim;
        lim = (size == '0) ? 0 : int'(size) - 1;
        if (lim > COORD_MAX) lim = COORD_MAX;
        if (v < 0) v = 0;
        if (v > lim) v = lim;
        return v;
    endfunction

    function automatic bit track_mouse_byte(input logic [7:0] b, output t_cursor res);
        logic [7:0] h;
        res = '0;
        if (skip_first) begin
            skip_first = 1'b0;
            return 1'b0;
        end
        if (frame_ph == PH_XDELTA) begin
            x_byte = b;
            frame_ph = PH_YDELTA;
            return 1'b0;
        end
        if (frame_ph != PH_YDELTA) begin
            frame_ph = PH_HEADER;
            if ((b & HDR_VALID) == 8'h00) return 1'b0;
            hdr_byte = b;
            frame_ph = PH_XDELTA;
            return 1'b0;
        end
        frame_ph = PH_HEADER;
        h = hdr_byte;
        cur_x += axis_move(x_byte, h[4], h[6]);
        cur_y -= axis_move(b, h[5], h[7]);
        cur_x = clamp_to(cur_x, scr_w);
        cur_y = clamp_to(cur_y, scr_h);
        res.x = cur_x[COORD_BITS-1:0];
        res.y = cur_y[COORD_BITS-1:0];
        res.left = h[0];
        res.right = h[1];
        res.mid = h[2];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        if (err_count <= 40)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge i_clk) begin : monitor
        t_cursor pred;
        t_cursor want;
        logic [OUT_BITS-1:0] pad;
        bit made;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH: scr_w = i_cfg_data;
                REG_SCREEN_HEIGHT: scr_h = i_cfg_data;
                default: ;
            endcase
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            made = track_mouse_byte(s_axis_tdata, pred);
            if (made) cursor_q.push_back(row_typed ? row_want : pred);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cursor_q.size() == 0) begin
                report_mismatch("unexpected result", longint'(m_axis_tdata), longint'(0));
            end else begin
                want = cursor_q.pop_front();
                pad = m_axis_tdata >> (2 * COORD_BITS + 3);
                if (m_axis_tdata[COORD_BITS-1:0] !== want.x)
                    report_mismatch("cursor_x", longint'(m_axis_tdata[COORD_BITS-1:0]),
                                    longint'(want.x));
                if (m_axis_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
                    report_mismatch("cursor_y",
                                    longint'(m_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
                                    longint'(want.y));
                if (m_axis_tdata[2*COORD_BITS] !== want.left)
                    report_mismatch("button_left", longint'(m_axis_tdata[2*COORD_BITS]),
                                    longint'(want.left));
                if (m_axis_tdata[2*COORD_BITS+1] !== want.right)
                    report_mismatch("button_right", longint'(m_axis_tdata[2*COORD_BITS+1]),
                                    longint'(want.right));
                if (m_axis_tdata[2*COORD_BITS+2] !== want.mid)
                    report_mismatch("button_middle", longint'(m_axis_tdata[2*COORD_BITS+2]),
                                    longint'(want.mid));
                if (pad !== '0)
                    report_mismatch("padding", longint'(pad), longint'(0));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: periodic stall pattern, or a long hold when asked.
    always @(negedge i_clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            rx_cnt++;
            m_axis_tready = (rx_cnt % rx_period) >= rx_low;
        end
    end

    // Call at a falling edge; returns at a falling edge.
    task automatic offer_byte(input logic [7:0] b, input bit typed, input t_cursor want);
        int gap;
        s_axis_tdata = b;
        row_typed = typed;
        row_want = want;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, burst_max);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop offering and wait until every expected result is out.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (cursor_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [SIZE_BITS-1:0] v);
        i_cfg_index = idx;
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_step byte_row(input logic [7:0] b);
        t_step s;
        s = '0;
        s.val = SIZE_BITS'(b);
        return s;
    endfunction

    function automatic t_step typed_row(input logic [7:0] b, input int x, input int y,
                                        input bit l, input bit r, input bit m);
        t_step s;
        s = byte_row(b);
        s.typed = 1'b1;
        s.want.x = x[COORD_BITS-1:0];
        s.want.y = y[COORD_BITS-1:0];
        s.want.left = l;
        s.want.right = r;
        s.want.mid = m;
        return s;
    endfunction

    function automatic t_step cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [SIZE_BITS-1:0] v);
        t_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.val = v;
        return s;
    endfunction

    initial begin
        t_step dir_tab[$];
        logic [7:0] stream[$];
        logic [SIZE_BITS-1:0] w;
        logic [SIZE_BITS-1:0] h;
        logic [7:0] hdr;
        logic [7:0] nb;
        int phase;
        int roll;
        bit drift;
        bit dxn;
        bit dyn;

        // dropped first byte, then rejected headers
        dir_tab.push_back(byte_row(8'hFF));
        dir_tab.push_back(byte_row(8'h00));
        dir_tab.push_back(byte_row(8'hF7));
        dir_tab.push_back(byte_row(8'h08));
        dir_tab.push_back(byte_row(8'h00));
        dir_tab.push_back(typed_row(8'h00, 0, 0, 0, 0, 0));
        dir_tab.push_back(byte_row(8'h0F));
        dir_tab.push_back(byte_row(8'hFF));
        dir_tab.push_back(typed_row(8'h00, 255, 0, 1, 1, 1));
        // X overflow, Y sign, zero bytes with every sign and overflow set
        dir_tab.push_back(byte_row(8'h48));
        dir_tab.push_back(byte_row(8'hFF));
        dir_tab.push_back(byte_row(8'h00));
        dir_tab.push_back(byte_row(8'h28));
        dir_tab.push_back(byte_row(8'h00));
        dir_tab.push_back(byte_row(8'h01));
        dir_tab.push_back(byte_row(8'hF8));
        dir_tab.push_back(byte_row(8'h00));
        dir_tab.push_back(byte_row(8'h00));
        dir_tab.push_back(byte_row(8'h57));
        // zero width, oversized height, ignored indexes
        dir_tab.push_back(cfg_row(REG_SCREEN_WIDTH, '0));
        dir_tab.push_back(cfg_row(REG_SCREEN_HEIGHT, '1));
        dir_tab.push_back(cfg_row(CFG_IDX_BITS'(2), SIZE_BITS'(5)));
        dir_tab.push_back(cfg_row(CFG_IDX_BITS'(3), '1));
        dir_tab.push_back(byte_row(8'h98));
        dir_tab.push_back(byte_row(8'h80));
        dir_tab.push_back(byte_row(8'h7F));
        // one-pixel screen pins the cursor at the origin
        dir_tab.push_back(cfg_row(REG_SCREEN_WIDTH, SIZE_BITS'(1)));
        dir_tab.push_back(cfg_row(REG_SCREEN_HEIGHT, SIZE_BITS'(1)));
        dir_tab.push_back(byte_row(8'h0B));
        dir_tab.push_back(byte_row(8'h40));
        dir_tab.push_back(typed_row(8'h40, 0, 0, 1, 1, 0));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                drain_results();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                offer_byte(dir_tab[i].val[7:0], dir_tab[i].typed, dir_tab[i].want);
            end
        end

        for (phase = 0; phase < 8; phase++) begin
            drain_results();
            case (phase)
                0: begin w = SIZE_BITS'(4096); h = SIZE_BITS'(4096); end
                1: begin w = '1; h = SIZE_BITS'(1); end
                2: begin w = RESET_WIDTH; h = RESET_HEIGHT; end
                default: begin
                    w = ($urandom_range(0, 3) == 0) ? SIZE_BITS'($urandom_range(0, 8191))
                                                    : SIZE_BITS'($urandom_range(1, 700));
                    h = ($urandom_range(0, 3) == 0) ? SIZE_BITS'($urandom_range(0, 8191))
                                                    : SIZE_BITS'($urandom_range(1, 700));
                end
            endcase
            write_reg(REG_SCREEN_WIDTH, w);
            write_reg(REG_SCREEN_HEIGHT, h);

            // drive toward a corner in the first phases to hit the clamps
            if (phase == 0) begin
                drift = 1'b1; dxn = 1'b0; dyn = 1'b1;
            end else if (phase == 1) begin
                drift = 1'b1; dxn = 1'b1; dyn = 1'b0;
            end else begin
                drift = 1'($urandom_range(0, 1));
                dxn = 1'($urandom_range(0, 1));
                dyn = 1'($urandom_range(0, 1));
            end

            if (phase % 3 == 0) begin
                rx_period = 1;
                rx_low = 0;
            end else begin
                rx_period = $urandom_range(2, 9);
                rx_low = $urandom_range(1, rx_period - 1);
            end
            if (phase == 2 || phase == 5) begin
                burst_max = 1000;
                gap_max = 0;
            end else begin
                burst_max = $urandom_range(1, 12);
                gap_max = $urandom_range(1, 6);
            end
            burst_left = 0;
            // hold the output while the input keeps coming, so the queue fills
            if (phase == 2) hold_asked++;

            stream.delete();
            while (stream.size() < 66) begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    nb = 8'($urandom);
                    stream.push_back(nb);
                end else begin
                    hdr = 8'($urandom);
                    hdr[3] = 1'b1;
                    if (drift) begin
                        hdr[4] = dxn;
                        hdr[5] = dyn;
                        hdr[6] = 1'($urandom_range(0, 1));
                        hdr[7] = 1'($urandom_range(0, 1));
                    end
                    stream.push_back(hdr);
                    // truncate a few packets to break the framing
                    if (roll >= 16) begin
                        nb = 8'($urandom);
                        stream.push_back(nb);
                        if (roll >= 20) begin
                            nb = 8'($urandom);
                            stream.push_back(nb);
                        end
                    end
                end
            end
            foreach (stream[k]) offer_byte(stream[k], 1'b0, '0);
        end

        drain_results();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
